// File: design/dda_pkg.sv
// Shared package for the DDA line rasterizer: command codes, default
// widths and the command/status structs between controller and datapath.
// No dependencies.
package dda_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch endpoints, color, start both dividers
    logic div_run;     // one restoring-division iteration
    logic div_finish;  // write signed increments from the quotients
    logic advance;     // emit a pixel into the output register, step accumulators
  } dda_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;        // the next pixel ends the line
  } dda_stat_t;

endpackage

// File: design/dda_div.sv
// Restoring divider, one quotient bit per cycle while run is high: (mag << FRAC_BITS) / divisor.
// Used by dda_dp, one per axis; no package dependency.
module dda_div #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  start,
  input  logic                  run,
  input  logic [COORD_BITS-1:0] dividend_mag,
  input  logic [COORD_BITS-1:0] divisor,
  output logic [FRAC_BITS:0]    quot
);

  localparam int DVD_W = COORD_BITS + FRAC_BITS;

  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0]      dvd_r, dvd_nxt;
  logic [COORD_BITS-1:0] dvs_r, dvs_nxt;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    if (start) begin
      rem_nxt = '0;
      dvd_nxt = {dividend_mag, {FRAC_BITS{1'b0}}};
      dvs_nxt = divisor;
    end else if (run) begin
      // remainder stays below the divisor, so it fits the narrow register
      rem_nxt = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  // magnitude never exceeds the divisor, so the quotient is at most 2^FRAC_BITS
  assign quot = dvd_r[FRAC_BITS:0];

endmodule

// File: design/dda_dp.sv
// Datapath of the DDA line rasterizer: setup, two dividers, accumulators,
// pixel counter and output register. Depends on dda_pkg and dda_div.
module dda_dp #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dda_pkg::dda_cmd_t            cmd,
  output dda_pkg::dda_stat_t           stat,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [31:0]                  line_color,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [31:0]                  pixel_color,
  output logic                         last_pixel
);
  import dda_pkg::*;

  localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int CNT_W  = COORD_BITS + 1;

  // setup
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]        ax_w, ay_w;
  logic [COORD_BITS-1:0]      ax, ay, steps_raw, steps;
  logic [FRAC_BITS:0]         qx, qy;

  assign dx   = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
  assign dy   = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
  assign ax_w = dx[COORD_BITS] ? -dx : dx;
  assign ay_w = dy[COORD_BITS] ? -dy : dy;
  assign ax   = ax_w[COORD_BITS-1:0];
  assign ay   = ay_w[COORD_BITS-1:0];
  assign steps_raw = (ax >= ay) ? ax : ay;
  assign steps     = (steps_raw == '0) ? COORD_BITS'(1) : steps_raw;

  dda_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .start(cmd.load), .run(cmd.div_run),
    .dividend_mag(ax), .divisor(steps), .quot(qx)
  );

  dda_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .start(cmd.load), .run(cmd.div_run),
    .dividend_mag(ay), .divisor(steps), .quot(qy)
  );

  logic [ACC_W-1:0]  xacc_r, xacc_nxt, yacc_r, yacc_nxt;
  logic [STEP_W-1:0] xstep_r, xstep_nxt, ystep_r, ystep_nxt;
  logic              xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [31:0]       color_r, color_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [31:0]       pcolor_r, pcolor_nxt;
  logic              plast_r, plast_nxt;
  logic              last;

  // round half away from zero: (acc + half - sign) >>> FRAC_BITS
  localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
  logic [ACC_W:0] xr, yr;
  assign xr = {xacc_r[ACC_W-1], xacc_r} + HALF - (ACC_W + 1)'(xacc_r[ACC_W-1]);
  assign yr = {yacc_r[ACC_W-1], yacc_r} + HALF - (ACC_W + 1)'(yacc_r[ACC_W-1]);

  assign last = (left_r <= CNT_W'(1));

  always_comb begin
    xacc_nxt   = xacc_r;
    yacc_nxt   = yacc_r;
    xstep_nxt  = xstep_r;
    ystep_nxt  = ystep_r;
    xneg_nxt   = xneg_r;
    yneg_nxt   = yneg_r;
    left_nxt   = left_r;
    color_nxt  = color_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    pcolor_nxt = pcolor_r;
    plast_nxt  = plast_r;
    if (cmd.load) begin
      xacc_nxt  = {start_x[COORD_BITS-1], start_x, {FRAC_BITS{1'b0}}};
      yacc_nxt  = {start_y[COORD_BITS-1], start_y, {FRAC_BITS{1'b0}}};
      xneg_nxt  = dx[COORD_BITS];
      yneg_nxt  = dy[COORD_BITS];
      left_nxt  = {1'b0, steps} + CNT_W'(1);
      color_nxt = line_color;
    end
    if (cmd.div_finish) begin
      xstep_nxt = xneg_r ? -{1'b0, qx} : {1'b0, qx};
      ystep_nxt = yneg_r ? -{1'b0, qy} : {1'b0, qy};
    end
    if (cmd.advance) begin
      px_nxt     = xr[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
      py_nxt     = yr[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
      pcolor_nxt = color_r;
      plast_nxt  = last;
      xacc_nxt   = xacc_r + {{(ACC_W-STEP_W){xstep_r[STEP_W-1]}}, xstep_r};
      yacc_nxt   = yacc_r + {{(ACC_W-STEP_W){ystep_r[STEP_W-1]}}, ystep_r};
      left_nxt   = last ? '0 : left_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xacc_r   <= xacc_nxt;
    yacc_r   <= yacc_nxt;
    xstep_r  <= xstep_nxt;
    ystep_r  <= ystep_nxt;
    xneg_r   <= xneg_nxt;
    yneg_r   <= yneg_nxt;
    color_r  <= color_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    pcolor_r <= pcolor_nxt;
    plast_r  <= plast_nxt;
  end

  assign stat.last   = last;
  assign pixel_x     = px_r;
  assign pixel_y     = py_r;
  assign pixel_color = pcolor_r;
  assign last_pixel  = plast_r;

endmodule

// File: design/dda_ctrl.sv
// Controller of the DDA line rasterizer: idle/divide/finish/run sequencing,
// input handshake and output valid. Depends on dda_pkg.
module dda_ctrl #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_cmd,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  dda_pkg::dda_stat_t stat,
  output dda_pkg::dda_cmd_t  cmd
);
  import dda_pkg::*;

  localparam int DIV_CYCLES = COORD_BITS + FRAC_BITS;
  localparam int DCNT_W     = $clog2(DIV_CYCLES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN,
    S_RUN
  } state_t;

  state_t            state_r, state_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  // hold off new items while dividing or finishing, or while a pixel waits that is not taken
  assign in_tready = (state_r != S_DIV) && (state_r != S_FIN) &&
                     (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd            = '0;
    cmd.load       = accept && (in_cmd == CMD_LOAD);
    cmd.advance    = accept && (in_cmd == CMD_STEP) && (state_r == S_RUN);
    cmd.div_run    = (state_r == S_DIV);
    cmd.div_finish = (state_r == S_FIN);
  end

  always_comb begin
    state_nxt     = state_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.advance) begin
      out_valid_nxt = 1'b1;
    end
    unique case (state_r) inside
      S_IDLE, S_RUN: begin
        if (cmd.load) begin
          state_nxt = S_DIV;
          dcnt_nxt  = '0;
        end else if (cmd.advance && stat.last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_CYCLES - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_RUN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_FIN) |-> !in_tready)
    else $error("item accepted during division");

  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DIV && dcnt_r == '0))
    else $error("load did not start the divider");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && stat.last) |=> (state_r == S_IDLE))
    else $error("line did not end after its last pixel");

  a_valid_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.advance))
    else $error("output valid without an emitted pixel");
`endif

endmodule

// File: design/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: stream ports, field packing, and
// the controller/datapath pair. Depends on dda_pkg, dda_ctrl, dda_dp, dda_div.
//
// Usage:
//   Input channel (in_*): in_tuser carries the command. A load item latches
//   start/end points and a color; a step item asks for the next pixel.
//   Output channel (out_*): one pixel item per step item while a line is
//   active, out_tlast marks the line's final pixel (steps+1 pixels per line).
//   Step items with no active line are taken and dropped.
//   Setup: after a load, in_tready stays low while the two restoring
//   dividers produce the per-axis increments, one quotient bit per cycle,
//   and then while the increments are written.
//   Each accepted step item shows its pixel on out_* the next cycle.
//   Throughput: one pixel per clock while the line runs and the receiver
//   takes each pixel; the single output register sets that figure.
//   Reset (rst_n low, synchronous): idle, no line, out_tvalid low.
//   Receiver stall: the pixel holds in the output register and in_tready
//   drops until out_tready returns, so no item is lost.
module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
  localparam int IN_W       = 4 * COORD_BITS + 32,
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = 2 * COORD_BITS + 32,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // start_x, start_y, end_x, end_y, line_color (low bit up), zero padded
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pixel_x, pixel_y, pixel_color (low bit up), zero padded
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);
  import dda_pkg::*;

  dda_cmd_t  cmd;
  dda_stat_t stat;

  logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
  logic [31:0]                  line_color;
  logic signed [COORD_BITS-1:0] pixel_x, pixel_y;
  logic [31:0]                  pixel_color;

  // unpack the input fields, lowest first
  assign start_x    = in_tdata[COORD_BITS-1:0];
  assign start_y    = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign end_x      = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign end_y      = in_tdata[4*COORD_BITS-1:3*COORD_BITS];
  assign line_color = in_tdata[4*COORD_BITS+31:4*COORD_BITS];

  dda_ctrl #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_cmd(in_tuser),
    .in_tready(in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat(stat),
    .cmd(cmd)
  );

  dda_dp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .stat(stat),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .line_color(line_color),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pixel_color(pixel_color),
    .last_pixel(out_tlast)
  );

  // pack the pixel, x in the lowest bits, pad with zeros to whole bytes
  assign out_tdata = OUT_TDATA_W'({pixel_color, pixel_y, pixel_x});

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for dda_line_rasterizer: directed lines from a stimulus
// table, then random line sequences with a bit-accurate rasterizer predictor.
// Depends on dda_pkg and the dda_line_rasterizer RTL.
module tb;
  import dda_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int FW          = FRAC_BITS_DEF;
  localparam int ACC_W       = CW + FW + 1;
  localparam int IN_TDATA_W  = ((4 * CW + 32 + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * CW + 32 + 7) / 8) * 8;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 5;
  localparam int TOTAL_ITEMS    = 550;  // loads plus steps that yield a pixel
  localparam int CALM_ITEMS     = 80;   // tail of the run with no idling at all
  localparam int HOLD_AT        = 150;
  localparam int DRAIN_AT       = 330;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES    = 40;   // divider latency plus margin
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DIR_ROWS       = 23;

  // How a directed row is checked
  typedef enum logic [1:0] {
    ROW_PRED,   // expectation comes from the predictor
    ROW_NONE,   // no pixel may come out of this item
    ROW_PIXEL   // pixel typed into the row
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        cmd;
    int          sx;
    int          sy;
    int          ex;
    int          ey;
    logic [31:0] color;  // load: line color; typed pixel: expected color
    int          px;
    int          py;
    logic        last;
  } dir_row_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [31:0]   color;
    logic          last;
  } pixel_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // start_x, start_y, end_x, end_y, line_color (low bit up), zero padded
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // cmd
  logic                   in_tuser = CMD_STEP;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  // pixel_x, pixel_y, pixel_color (low bit up), zero padded
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  dda_line_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Rasterizer state as the predictor sees it
  logic signed [ACC_W-1:0] line_x_acc = '0;
  logic signed [ACC_W-1:0] line_y_acc = '0;
  logic signed [FW+1:0]    line_x_inc = '0;
  logic signed [FW+1:0]    line_y_inc = '0;
  logic [CW:0]             line_left  = '0;
  logic [31:0]             line_color = '0;
  bit                      line_busy  = 1'b0;

  pixel_t pending_pixels [$];   // pixels owed by the block, oldest first

  int  work_items     = 0;
  int  lines_loaded   = 0;
  int  idle_dropped   = 0;
  int  pixels_checked = 0;
  int  mismatches     = 0;
  int  hold_asks      = 0;   // written by the sender only
  int  hold_served    = 0;   // written by the receiver only
  int  tx_rate        = 0;   // 0: no gaps, else one gap per tx_rate items on average
  bit  calm           = 1'b0;
  int  quiet_cycles   = 0;

  dir_row_t dir_rows [0:DIR_ROWS-1];

  // Per-axis increment: delta scaled to fixed point over the step count,
  // truncated toward zero.
  function automatic longint axis_increment(longint delta, longint span);
    longint q;
    q = ((delta < 0 ? -delta : delta) <<< FW) / span;
    return (delta < 0) ? -q : q;
  endfunction

  // Round an accumulator half away from zero, then keep the coordinate bits
  function automatic logic [CW-1:0] round_to_pixel(logic signed [ACC_W-1:0] acc);
    longint a;
    longint r;
    a = acc;
    r = ((a < 0 ? -a : a) + (64'sd1 <<< (FW - 1))) >>> FW;
    if (a < 0) r = -r;
    return r[CW-1:0];
  endfunction

  // Advance the predicted rasterizer by one accepted item; returns 1 when the
  // item yields a pixel, which is placed in px.
  function automatic bit raster_predict(logic cmd, logic [IN_TDATA_W-1:0] data,
                                        output pixel_t px);
    longint sx, sy, ex, ey, dx, dy, span;
    px = '0;
    if (cmd == CMD_LOAD) begin
      sx = longint'($signed(data[CW-1:0]));
      sy = longint'($signed(data[2*CW-1:CW]));
      ex = longint'($signed(data[3*CW-1:2*CW]));
      ey = longint'($signed(data[4*CW-1:3*CW]));
      dx = ex - sx;
      dy = ey - sy;
      span = (dx < 0) ? -dx : dx;
      if ((dy < 0 ? -dy : dy) > span) span = (dy < 0) ? -dy : dy;
      if (span == 0) span = 1;
      line_x_inc = (FW + 2)'(axis_increment(dx, span));
      line_y_inc = (FW + 2)'(axis_increment(dy, span));
      line_x_acc = ACC_W'(sx <<< FW);
      line_y_acc = ACC_W'(sy <<< FW);
      line_left  = (CW + 1)'(span + 1);
      line_color = data[4*CW+31:4*CW];
      line_busy  = 1'b1;
      lines_loaded++;
      return 1'b0;
    end
    if (!line_busy) begin
      idle_dropped++;
      return 1'b0;
    end
    px.x     = round_to_pixel(line_x_acc);
    px.y     = round_to_pixel(line_y_acc);
    px.color = line_color;
    px.last  = (line_left <= 1);
    line_x_acc = line_x_acc + line_x_inc;
    line_y_acc = line_y_acc + line_y_inc;
    if (line_left <= 1) begin
      line_left = '0;
      line_busy = 1'b0;
    end else begin
      line_left--;
    end
    return 1'b1;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_line(int sx, int sy, int ex, int ey,
                                                      logic [31:0] color);
    return {color, ey[CW-1:0], ex[CW-1:0], sy[CW-1:0], sx[CW-1:0]};
  endfunction

  function automatic int pick_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // Coordinate within reach of c, clamped to the field range
  function automatic int near_coord(int c, int reach);
    int v;
    v = c + int'($urandom_range(0, 2 * reach)) - reach;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch on pixel %0d: %s", pixels_checked, msg);
    mismatches++;
  endtask

  // Drop tvalid and let the sender idle
  task automatic idle_sender(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offer one item, hold it until accepted, then queue what it owes.
  // tvalid stays high after acceptance so back-to-back items need no toggle.
  task automatic send_item(logic cmd, logic [IN_TDATA_W-1:0] data, row_kind_e kind,
                           pixel_t typed);
    pixel_t px;
    bit     got;
    if (!calm && tx_rate != 0 && $urandom_range(1, tx_rate) == 1)
      idle_sender($urandom_range(1, 15));
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = raster_predict(cmd, data, px);
    if (cmd == CMD_LOAD || got) work_items++;
    if (kind == ROW_PIXEL) pending_pixels.push_back(typed);
    else if (kind == ROW_PRED && got) pending_pixels.push_back(px);
  endtask

  task automatic send_step();
    send_item(CMD_STEP, pack_line(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              $urandom), ROW_PRED, '0);
  endtask

  // Sender: directed table, then random line sequences
  initial begin : sender
    dir_row_t row;
    pixel_t   typed;
    int       sx, sy, ex, ey, reach, n, pick;
    bit       drained_mid;

    drained_mid = 1'b0;
    dir_rows = '{
      // step with no line: dropped
      '{ROW_NONE,  CMD_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 1'b0},
      // equal endpoints: two identical pixels, second flagged
      '{ROW_NONE,  CMD_LOAD, 0, 0, 0, 0, 32'hDEADBEEF, 0, 0, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'hDEADBEEF, 0, 0, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'hDEADBEEF, 0, 0, 1'b1},
      '{ROW_NONE,  CMD_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 1'b0},
      // full-range diagonal, left open
      '{ROW_NONE,  CMD_LOAD, -2048, -2048, 2047, 2047, 32'hFFFFFFFF, 0, 0, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'hFFFFFFFF, -2048, -2048, 1'b0},
      '{ROW_PRED,  CMD_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 1'b0},
      // load while busy replaces the line
      '{ROW_NONE,  CMD_LOAD, 2047, 0, -2048, 5, 32'h00000000, 0, 0, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'h00000000, 2047, 0, 1'b0},
      '{ROW_PRED,  CMD_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 1'b0},
      // exact half rounds up on a positive axis
      '{ROW_NONE,  CMD_LOAD, 0, 0, 1, 2, 32'h12345678, 0, 0, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'h12345678, 0, 0, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'h12345678, 1, 1, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'h12345678, 1, 2, 1'b1},
      // and away from zero on a negative axis
      '{ROW_NONE,  CMD_LOAD, 0, 0, -1, -2, 32'hA5A5A5A5, 0, 0, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'hA5A5A5A5, 0, 0, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'hA5A5A5A5, -1, -1, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'hA5A5A5A5, -1, -2, 1'b1},
      '{ROW_NONE,  CMD_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 1'b0},
      // full-range vertical
      '{ROW_NONE,  CMD_LOAD, 0, 2047, 0, -2048, 32'h5A5A5A5A, 0, 0, 1'b0},
      '{ROW_PIXEL, CMD_STEP, 0, 0, 0, 0, 32'h5A5A5A5A, 0, 2047, 1'b0},
      '{ROW_PRED,  CMD_STEP, 0, 0, 0, 0, 32'h0, 0, 0, 1'b0}
    };

    while (!rst_n) @(posedge clk);
    tx_rate = 3;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      typed.x     = row.px[CW-1:0];
      typed.y     = row.py[CW-1:0];
      typed.color = row.color;
      typed.last  = row.last;
      send_item(row.cmd, pack_line(row.sx, row.sy, row.ex, row.ey, row.color),
                row.kind, typed);
    end
    // Pause until the directed pixels are all back
    idle_sender(1);
    while (pending_pixels.size() != 0) @(posedge clk);

    while (work_items < TOTAL_ITEMS) begin
      calm = (work_items >= TOTAL_ITEMS - CALM_ITEMS);
      case ($urandom_range(0, 2))
        0:       tx_rate = 0;
        1:       tx_rate = 3;
        default: tx_rate = 10;
      endcase
      if (hold_asks == 0 && work_items >= HOLD_AT) begin
        // Long receiver hold-off under an 80-pixel line: the output register
        // fills and in_tready must drop while steps keep coming.
        hold_asks = 1;
        sx = int'($urandom_range(0, 3900)) - 2048;
        sy = pick_coord();
        send_item(CMD_LOAD, pack_line(sx, sy, sx + 79, sy, $urandom), ROW_PRED, '0);
        repeat (80) send_step();
      end else if (!drained_mid && work_items >= DRAIN_AT) begin
        idle_sender(1);
        while (pending_pixels.size() != 0) @(posedge clk);
        drained_mid = 1'b1;
      end else begin
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          send_step();   // stray step: dropped when idle, else continues a line
        end else begin
          sx = pick_coord();
          sy = pick_coord();
          if (pick <= 2) begin
            ex = pick_coord();
            ey = pick_coord();
          end else begin
            reach = $urandom_range(0, 12);
            ex = near_coord(sx, reach);
            ey = near_coord(sy, reach);
          end
          send_item(CMD_LOAD, pack_line(sx, sy, ex, ey, $urandom), ROW_PRED, '0);
          n = int'(line_left);
          // Cut long lines short; truncate some short ones so the next load
          // lands mid-line.
          if (n > 40) n = $urandom_range(1, 24);
          else if (pick == 3) n = $urandom_range(0, n - 1);
          repeat (n) send_step();
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d lines loaded, %0d pixels checked, %0d idle steps dropped",
             lines_loaded, pixels_checked, idle_dropped);
    $display("tb: %0d long receiver hold-off(s), %0d mismatches", hold_served, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin : receiver
    int cyc;
    int rx_rate;
    cyc = 0;
    rx_rate = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_served < hold_asks) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else if (!calm && rx_rate != 0 && $urandom_range(1, rx_rate) == 1) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
        cyc++;
        // Change stall density now and then, with stall-free stretches
        if (cyc % 97 == 0) begin
          case ($urandom_range(0, 2))
            0:       rx_rate = 0;
            1:       rx_rate = 4;
            default: rx_rate = 12;
          endcase
        end
      end
    end
  end

  // Compare each accepted pixel with the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
                        $signed(out_tdata[CW-1:0]), $signed(out_tdata[2*CW-1:CW])));
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[CW-1:0] !== want.x)
          report_mismatch($sformatf("pixel_x %0d, want %0d",
                          $signed(out_tdata[CW-1:0]), $signed(want.x)));
        if (out_tdata[2*CW-1:CW] !== want.y)
          report_mismatch($sformatf("pixel_y %0d, want %0d",
                          $signed(out_tdata[2*CW-1:CW]), $signed(want.y)));
        if (out_tdata[2*CW+31:2*CW] !== want.color)
          report_mismatch($sformatf("pixel_color %h, want %h",
                          out_tdata[2*CW+31:2*CW], want.color));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last_pixel %b, want %b", out_tlast, want.last));
      end
      pixels_checked++;
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else if (rst_n) quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: timeout after %0d quiet cycles, %0d pixels outstanding",
               quiet_cycles, pending_pixels.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule
